[design/slvg_pkg.sv]
`timescale 1ns / 1ps

package slvg_pkg;

  localparam int COUNT_WIDTH_DEF = 8;
  localparam int WAYPOINT_W      = 16;
  localparam int WINDOW_W        = 8;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_POINT_A = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_POINT_B = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LEN   = 2'd2;

  localparam logic signed [WAYPOINT_W-1:0] STOP_POINT_A_RST = 16'sd10;
  localparam logic signed [WAYPOINT_W-1:0] STOP_POINT_B_RST = 16'sd20;
  localparam logic [WINDOW_W-1:0]          WINDOW_LEN_RST   = 8'd15;

  // The go phase is never held: reaching it clears the whole gate.
  typedef enum logic [1:0] {
    PH_OTHER = 2'b01,
    PH_RED   = 2'b10
  } phase_t;

  typedef struct packed {
    logic                          mode;
    logic signed [WAYPOINT_W-1:0]  waypoint;
    logic                          detected;
    logic                          red_hit;
    logic                          blue_hit;
  } item_t;

  typedef struct packed {
    logic signed [WAYPOINT_W-1:0] stop_point_a;
    logic signed [WAYPOINT_W-1:0] stop_point_b;
    logic [WINDOW_W-1:0]          window_len;
  } cfg_t;

  typedef struct packed {
    logic produce;
    logic runnable;
  } res_t;

endpackage

[design/slvg_core.sv]
`timescale 1ns / 1ps

module slvg_core #(
  parameter int COUNT_WIDTH = slvg_pkg::COUNT_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  slvg_pkg::item_t item,
  input  slvg_pkg::cfg_t  cfg,
  output slvg_pkg::res_t  res
);

  localparam int CW    = COUNT_WIDTH;
  localparam int CMP_W = (CW > slvg_pkg::WINDOW_W) ? CW : slvg_pkg::WINDOW_W;
  localparam int RW    = CW + 4;

  logic             armed_r, armed_nxt;
  logic             present_r, present_nxt;
  slvg_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0]    frame_r, frame_nxt;
  logic [CW-1:0]    detect_r, detect_nxt;
  logic [CW-1:0]    red_r, red_nxt;
  logic [CW-1:0]    blue_r, blue_nxt;

  logic [CW-1:0]    frame_inc, detect_inc, red_inc, blue_inc;
  logic [CMP_W-1:0] win_ext;
  logic             pres_close, col_close, pres_win, red_win, blue_win, go;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (v == {CW{1'b1}}) ? v : v + 1'b1;
  endfunction

  always_comb begin
    win_ext    = CMP_W'(cfg.window_len);
    frame_inc  = sat_inc(frame_r);
    detect_inc = item.detected ? sat_inc(detect_r) : detect_r;
    red_inc    = item.red_hit ? sat_inc(red_r) : red_r;
    blue_inc   = item.blue_hit ? sat_inc(blue_r) : blue_r;
    pres_close = CMP_W'(frame_inc) >= win_ext;
    col_close  = CMP_W'(detect_inc) >= win_ext;
    pres_win   = (RW'(detect_inc) * RW'(10)) > (RW'(frame_inc) * RW'(7));
    red_win    = (RW'(red_inc) * RW'(5)) > (RW'(detect_inc) * RW'(4));
    blue_win   = (RW'(blue_inc) * RW'(5)) > (RW'(detect_inc) * RW'(4));
    go         = 1'b0;

    armed_nxt   = armed_r;
    present_nxt = present_r;
    phase_nxt   = phase_r;
    frame_nxt   = frame_r;
    detect_nxt  = detect_r;
    red_nxt     = red_r;
    blue_nxt    = blue_r;
    res         = '0;

    if (step) begin
      if (!item.mode) begin
        if (item.waypoint == cfg.stop_point_a || item.waypoint == cfg.stop_point_b) begin
          armed_nxt = 1'b1;
        end else begin
          armed_nxt   = 1'b0;
          present_nxt = 1'b0;
          phase_nxt   = slvg_pkg::PH_OTHER;
          frame_nxt   = '0;
          detect_nxt  = '0;
          red_nxt     = '0;
          blue_nxt    = '0;
        end
      end else if (armed_r && !present_r) begin
        frame_nxt  = frame_inc;
        detect_nxt = detect_inc;
        if (pres_close) begin
          if (pres_win) begin
            present_nxt = 1'b1;
          end else begin
            frame_nxt = '0;
          end
          detect_nxt = '0;
        end
      end else if (armed_r) begin
        res.produce = 1'b1;
        if (item.detected) begin
          detect_nxt = detect_inc;
          red_nxt    = red_inc;
          blue_nxt   = blue_inc;
          if (col_close) begin
            detect_nxt = '0;
            red_nxt    = '0;
            blue_nxt   = '0;
            if (red_win) begin
              phase_nxt = slvg_pkg::PH_RED;
            end else begin
              unique case (phase_r)
                slvg_pkg::PH_RED:   go = blue_win;
                slvg_pkg::PH_OTHER: go = 1'b0;
                default:            go = 1'b0;
              endcase
            end
          end
        end
        if (go) begin
          res.runnable = 1'b1;
          armed_nxt    = 1'b0;
          present_nxt  = 1'b0;
          phase_nxt    = slvg_pkg::PH_OTHER;
          frame_nxt    = '0;
          detect_nxt   = '0;
          red_nxt      = '0;
          blue_nxt     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      present_r <= 1'b0;
      phase_r   <= slvg_pkg::PH_OTHER;
      frame_r   <= '0;
      detect_r  <= '0;
      red_r     <= '0;
      blue_r    <= '0;
    end else begin
      armed_r   <= armed_nxt;
      present_r <= present_nxt;
      phase_r   <= phase_nxt;
      frame_r   <= frame_nxt;
      detect_r  <= detect_nxt;
      red_r     <= red_nxt;
      blue_r    <= blue_nxt;
    end
  end

endmodule

[design/signal_light_vote_gate.sv]
`timescale 1ns / 1ps
// Channel   Ports                                                  Moves
// input     in_valid, in_stall, in_mode, in_waypoint, in_detected,
//           in_red_hit, in_blue_hit                                one item per transfer
// result    out_valid, out_stall, out_runnable                     zero or one per item
// config    cfg_we, cfg_index, cfg_wdata                           one register per write
//
// An item is registered on transfer and evaluated when it advances from the input register;
// its result, if any, is registered into the output register as the item advances.
// One item per cycle is sustained while the result side does not stall.
// Reset is synchronous and active low; it clears all counters, the arm bit and the phase,
// and loads the register defaults.
// in_stall rises only while an item waits in the input register behind a stalled result.

module signal_light_vote_gate #(
  parameter int COUNT_WIDTH = slvg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_mode,
  input  logic signed [slvg_pkg::WAYPOINT_W-1:0] in_waypoint,
  input  logic                                   in_detected,
  input  logic                                   in_red_hit,
  input  logic                                   in_blue_hit,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_runnable,
  input  logic                                   cfg_we,
  input  logic [slvg_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [slvg_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  slvg_pkg::cfg_t  cfg_r;
  slvg_pkg::item_t item_r;
  slvg_pkg::res_t  res;
  logic            item_valid_r, item_valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_runnable_r;
  logic            advance, in_xfer;

  assign advance  = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = in_xfer || (item_valid_r && !advance);
    if (advance) begin
      out_valid_nxt = res.produce;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_point_a <= slvg_pkg::STOP_POINT_A_RST;
      cfg_r.stop_point_b <= slvg_pkg::STOP_POINT_B_RST;
      cfg_r.window_len   <= slvg_pkg::WINDOW_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slvg_pkg::CFG_STOP_POINT_A: cfg_r.stop_point_a <= cfg_wdata;
        slvg_pkg::CFG_STOP_POINT_B: cfg_r.stop_point_b <= cfg_wdata;
        slvg_pkg::CFG_WINDOW_LEN:   cfg_r.window_len <= cfg_wdata[slvg_pkg::WINDOW_W-1:0];
        default:                    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.mode     <= in_mode;
      item_r.waypoint <= in_waypoint;
      item_r.detected <= in_detected;
      item_r.red_hit  <= in_red_hit;
      item_r.blue_hit <= in_blue_hit;
    end
    if (advance) begin
      out_runnable_r <= res.runnable;
    end
  end

  slvg_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (advance),
    .item (item_r),
    .cfg  (cfg_r),
    .res  (res)
  );

  assign out_valid    = out_valid_r;
  assign out_runnable = out_runnable_r;

endmodule

[design/slvg_checker.sv]
`timescale 1ns / 1ps

module slvg_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_runnable
);

  // A stalled result stays offered with the same value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_runnable))
    else $error("stalled result changed or dropped");

  // Input stall only comes from a stalled, occupied result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A reset leaves no result offered.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // Input stall persists while the result stays stalled.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && out_stall |=> in_stall || !out_stall)
    else $error("input stall released while result still stalled");

endmodule

bind signal_light_vote_gate slvg_checker u_slvg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_runnable(out_runnable)
);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int CW = slvg_pkg::COUNT_WIDTH_DEF;

  typedef enum logic [1:0] {
    STAGE_OTHER,
    STAGE_RED,
    STAGE_GO
  } stage_t;

  typedef enum logic {
    ROW_STEP,
    ROW_REG
  } row_kind_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_LOW,
    CHK_HIGH
  } chk_t;

  typedef struct packed {
    row_kind_t                       kind;
    chk_t                            chk;
    logic [slvg_pkg::CFG_INDEX_W-1:0] reg_idx;
    logic [slvg_pkg::CFG_DATA_W-1:0]  reg_val;
    slvg_pkg::item_t                 it;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_mode;
  logic signed [slvg_pkg::WAYPOINT_W-1:0] in_waypoint;
  logic in_detected;
  logic in_red_hit;
  logic in_blue_hit;
  logic out_valid;
  logic out_stall;
  logic out_runnable;
  logic cfg_we;
  logic [slvg_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [slvg_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copy of the gate: registers and voting state.
  logic [slvg_pkg::WAYPOINT_W-1:0] stop_a;
  logic [slvg_pkg::WAYPOINT_W-1:0] stop_b;
  logic [slvg_pkg::WINDOW_W-1:0]   win_len;
  logic                            gate_armed;
  logic                            light_seen;
  stage_t                          light_stage;
  logic [CW-1:0]                   win_frames;
  logic [CW-1:0]                   win_detects;
  logic [CW-1:0]                   win_reds;
  logic [CW-1:0]                   win_blues;

  logic expected_runnable[$];
  row_t rows[$];
  logic want_runnable;
  int   n_sent;
  int   results_seen;
  int   mismatches;
  int   hold_left;
  bit   hold_done;

  signal_light_vote_gate u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_waypoint (in_waypoint),
    .in_detected (in_detected),
    .in_red_hit  (in_red_hit),
    .in_blue_hit (in_blue_hit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_runnable(out_runnable),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CW-1:0] bump(logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + 1'b1;
  endfunction

  task automatic add_expect(input logic v);
    expected_runnable = {expected_runnable, v};
  endtask

  task automatic add_row(input row_t row);
    rows = {rows, row};
  endtask

  task automatic clear_gate();
    gate_armed  = 1'b0;
    light_seen  = 1'b0;
    light_stage = STAGE_OTHER;
    win_frames  = '0;
    win_detects = '0;
    win_reds    = '0;
    win_blues   = '0;
  endtask

  task automatic predict_gate(input slvg_pkg::item_t it, output logic has_res,
                              output logic res);
    has_res = 1'b0;
    res     = 1'b0;
    if (!it.mode) begin
      if (it.waypoint == stop_a || it.waypoint == stop_b) begin
        gate_armed = 1'b1;
      end else begin
        clear_gate();
      end
    end else if (gate_armed && !light_seen) begin
      win_frames = bump(win_frames);
      if (it.detected) win_detects = bump(win_detects);
      if (win_frames >= win_len) begin
        if (int'(win_detects) * 10 > int'(win_frames) * 7) begin
          light_seen = 1'b1;
        end else begin
          win_frames = '0;
        end
        win_detects = '0;
      end
    end else if (gate_armed) begin
      if (it.detected) begin
        win_detects = bump(win_detects);
        if (it.red_hit) win_reds = bump(win_reds);
        if (it.blue_hit) win_blues = bump(win_blues);
        if (win_detects >= win_len) begin
          if (int'(win_reds) * 5 > int'(win_detects) * 4) begin
            light_stage = STAGE_RED;
          end else if (int'(win_blues) * 5 > int'(win_detects) * 4 &&
                       light_stage == STAGE_RED) begin
            light_stage = STAGE_GO;
          end
          win_reds    = '0;
          win_blues   = '0;
          win_detects = '0;
        end
      end
      has_res = 1'b1;
      if (light_stage == STAGE_GO) begin
        res = 1'b1;
        clear_gate();
      end
    end
  endtask

  function automatic row_t step_row(chk_t c, logic m, logic [15:0] wp, logic d, logic r,
                                    logic b);
    row_t row;
    row = '0;
    row.kind = ROW_STEP;
    row.chk = c;
    row.it.mode = m;
    row.it.waypoint = wp;
    row.it.detected = d;
    row.it.red_hit = r;
    row.it.blue_hit = b;
    return row;
  endfunction

  function automatic row_t reg_row(logic [slvg_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [slvg_pkg::CFG_DATA_W-1:0] v);
    row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.chk = CHK_NONE;
    row.reg_idx = idx;
    row.reg_val = v;
    return row;
  endfunction

  task automatic push_item(input slvg_pkg::item_t it, input chk_t chk);
    logic has_res;
    logic res;
    while ($urandom_range(99) < (n_sent < 185 ? 11 : (n_sent < 370 ? 46 : 0))) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= it.mode;
    in_waypoint <= it.waypoint;
    in_detected <= it.detected;
    in_red_hit  <= it.red_hit;
    in_blue_hit <= it.blue_hit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    predict_gate(it, has_res, res);
    case (chk)
      CHK_MODEL: if (has_res) add_expect(res);
      CHK_LOW:   add_expect(1'b0);
      CHK_HIGH:  add_expect(1'b1);
      default:   ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_runnable.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [slvg_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [slvg_pkg::CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      slvg_pkg::CFG_STOP_POINT_A: stop_a = v;
      slvg_pkg::CFG_STOP_POINT_B: stop_b = v;
      slvg_pkg::CFG_WINDOW_LEN:   win_len = v[slvg_pkg::WINDOW_W-1:0];
      default:                    ;
    endcase
  endtask

  task automatic make_item(input int noise, output slvg_pkg::item_t it);
    int r;
    r = $urandom_range(99);
    it.mode     = 1'b1;
    it.waypoint = 16'($urandom);
    it.detected = $urandom_range(99) < 88;
    it.red_hit  = 1'($urandom_range(1));
    it.blue_hit = 1'($urandom_range(1));
    if (!gate_armed) begin
      if (r < 80) begin
        it.mode = 1'b0;
        it.waypoint = $urandom_range(1) ? stop_a : stop_b;
      end else if (r < 90) begin
        it.mode = 1'b0;
      end
    end else if (r < noise) begin
      it.mode = 1'b0;
    end else if (r < 2 * noise) begin
      it.mode = 1'b0;
      it.waypoint = $urandom_range(1) ? stop_a : stop_b;
    end else if (light_seen && light_stage == STAGE_RED) begin
      it.red_hit  = $urandom_range(99) < 12;
      it.blue_hit = $urandom_range(99) < 92;
    end else if (light_seen) begin
      it.red_hit  = $urandom_range(99) < 90;
      it.blue_hit = $urandom_range(99) < 30;
    end
  endtask

  task automatic run_phase(input logic [15:0] a, input logic [15:0] b, input logic [7:0] wl,
                           input int count, input int noise);
    slvg_pkg::item_t it;
    settle();
    write_reg(slvg_pkg::CFG_STOP_POINT_A, a);
    write_reg(slvg_pkg::CFG_STOP_POINT_B, b);
    write_reg(slvg_pkg::CFG_WINDOW_LEN, {8'($urandom), wl});
    cfg_we <= 1'b0;
    repeat (count) begin
      make_item(noise, it);
      push_item(it, CHK_MODEL);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_runnable.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result transfer: runnable=%0b", out_runnable);
          end
        end else begin
          want_runnable = expected_runnable.pop_front();
          if (out_runnable !== want_runnable) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("runnable mismatch: expected %0b, got %0b", want_runnable,
                       out_runnable);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (results_seen >= 40 && in_valid && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 59;
        out_stall <= 1'b1;
      end else begin
        out_stall <= $urandom_range(99) < (n_sent < 185 ? 46 : (n_sent < 370 ? 11 : 0));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("signal_light_vote_gate test failed");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_mode     <= 1'b0;
    in_waypoint <= '0;
    in_detected <= 1'b0;
    in_red_hit  <= 1'b0;
    in_blue_hit <= 1'b0;
    out_stall   <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    n_sent = 0;
    results_seen = 0;
    mismatches = 0;
    hold_left = 0;
    hold_done = 1'b0;
    stop_a  = slvg_pkg::STOP_POINT_A_RST;
    stop_b  = slvg_pkg::STOP_POINT_B_RST;
    win_len = slvg_pkg::WINDOW_LEN_RST;
    clear_gate();

    add_row(step_row(CHK_NONE, 1'b1, 16'h00FF, 1'b1, 1'b1, 1'b1));
    add_row(step_row(CHK_NONE, 1'b0, 16'd10, 1'b0, 1'b0, 1'b0));
    add_row(step_row(CHK_NONE, 1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    add_row(step_row(CHK_NONE, 1'b0, 16'd20, 1'b0, 1'b0, 1'b0));
    add_row(reg_row(slvg_pkg::CFG_WINDOW_LEN, 16'h0001));
    add_row(step_row(CHK_NONE, 1'b1, 16'h5A5A, 1'b0, 1'b1, 1'b1));
    add_row(step_row(CHK_NONE, 1'b1, 16'hA5A5, 1'b1, 1'b0, 1'b0));
    add_row(step_row(CHK_LOW, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b0));
    add_row(step_row(CHK_LOW, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1));
    add_row(step_row(CHK_HIGH, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b1));
    add_row(step_row(CHK_NONE, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1));
    add_row(step_row(CHK_NONE, 1'b0, 16'd10, 1'b0, 1'b0, 1'b0));
    add_row(step_row(CHK_NONE, 1'b1, 16'h1234, 1'b1, 1'b0, 1'b0));
    add_row(step_row(CHK_LOW, 1'b1, 16'h1234, 1'b1, 1'b1, 1'b1));
    add_row(step_row(CHK_HIGH, 1'b1, 16'h1234, 1'b1, 1'b0, 1'b1));
    add_row(step_row(CHK_NONE, 1'b0, 16'd20, 1'b0, 1'b0, 1'b0));
    add_row(step_row(CHK_NONE, 1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b0));
    add_row(step_row(CHK_LOW, 1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b1));
    add_row(step_row(CHK_MODEL, 1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b0));
    add_row(reg_row(slvg_pkg::CFG_STOP_POINT_A, 16'h8000));
    add_row(reg_row(slvg_pkg::CFG_STOP_POINT_B, 16'h7FFF));
    add_row(reg_row(slvg_pkg::CFG_WINDOW_LEN, 16'hFF00));
    add_row(step_row(CHK_NONE, 1'b0, 16'd10, 1'b0, 1'b0, 1'b0));
    add_row(step_row(CHK_NONE, 1'b0, 16'h8000, 1'b0, 1'b0, 1'b0));
    add_row(step_row(CHK_NONE, 1'b0, 16'h7FFF, 1'b0, 1'b0, 1'b0));
    add_row(step_row(CHK_NONE, 1'b1, 16'h0F0F, 1'b0, 1'b0, 1'b0));
    add_row(step_row(CHK_NONE, 1'b1, 16'hF0F0, 1'b1, 1'b0, 1'b0));
    add_row(step_row(CHK_LOW, 1'b1, 16'h0F0F, 1'b1, 1'b1, 1'b0));
    add_row(step_row(CHK_HIGH, 1'b1, 16'hF0F0, 1'b1, 1'b0, 1'b1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        settle();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
        cfg_we <= 1'b0;
      end else begin
        push_item(rows[i].it, rows[i].chk);
      end
    end

    run_phase(16'd5, 16'hFFFB, 8'd1, 60, 4);
    run_phase(16'($urandom), 16'($urandom), 8'd0, 40, 4);
    run_phase(16'hFFFF, 16'h0000, 8'd4, 150, 3);
    run_phase(16'($urandom), 16'h8000, 8'd255, 260, 0);
    run_phase(slvg_pkg::STOP_POINT_A_RST, slvg_pkg::STOP_POINT_B_RST,
              slvg_pkg::WINDOW_LEN_RST, 40, 1);

    in_valid <= 1'b0;
    while (expected_runnable.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_runnable.size() == 0) begin
      $display("signal_light_vote_gate test passed");
    end else begin
      $display("signal_light_vote_gate test failed");
    end
    $finish;
  end

endmodule
